/* design/midi_voice_note_stack_unit_macros.svh */
// ----------------------------------------------------------------------------
// MIDI voice note stack assertion macros
// Shared concurrent assertion wrappers on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef MIDI_VOICE_NOTE_STACK_UNIT_MACROS_SVH
`define MIDI_VOICE_NOTE_STACK_UNIT_MACROS_SVH

// Checked only outside reset.
`define NSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define NSU_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/nsu_pkg.sv */
// ----------------------------------------------------------------------------
// nsu_pkg
// Types, constants and helpers shared by the MIDI voice note stack unit.
// ----------------------------------------------------------------------------
package nsu_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int VOICE_COUNT = 4;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int VOICE_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

	localparam logic [7:0] BYTE_RESET  = 8'hFF;
	localparam logic [7:0] BYTE_RT_MIN = 8'hF8;
	localparam logic [3:0] KIND_OFF    = 4'h8;
	localparam logic [3:0] KIND_ON     = 4'h9;
	localparam logic [3:0] KIND_BEND   = 4'hE;
	localparam logic [3:0] CHAN_ALLOC  = 4'd4;
	localparam logic [1:0] IDX_STATUS  = 2'd0;
	localparam logic [1:0] IDX_FIRST   = 2'd1;
	localparam logic [1:0] IDX_SECOND  = 2'd2;
	localparam logic [6:0] RANGE_LO    = 7'd69;
	localparam logic [6:0] RANGE_HI    = 7'd89;
	localparam logic [6:0] BEND_FLIP   = 7'h40;
	localparam logic [6:0] HOME_EVEN   = 7'd72;
	localparam logic [6:0] HOME_ODD    = 7'd82;
	localparam logic [8:0] BUSY_COST   = 9'd100;

	typedef enum logic [1:0] {
		ACT_OPEN,
		ACT_RETUNE,
		ACT_CLOSE,
		ACT_RESET
	} act_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_MARK,
		CMD_SORT_EVEN,
		CMD_SORT_ODD,
		CMD_SHIFT
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [6:0] note;
	} ctl_t;

	typedef struct packed {
		logic [6:0] top;
		logic       hole0;
		logic       hit;
	} stat_t;

	typedef struct packed {
		logic              all_idle;
		logic              pitch_in_range;
		logic signed [6:0] bend_offset;
		logic [6:0]        note;
		act_t              action;
		logic [1:0]        voice;
	} res_t;

	localparam int RES_W   = $bits(res_t);
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESET,
		ST_DISPATCH,
		ST_BEND,
		ST_ON,
		ST_OFF_NEXT,
		ST_MARK,
		ST_SORT,
		ST_COUNT,
		ST_OFF_EMIT,
		ST_FLUSH
	} state_t;

	function automatic logic in_range(logic [6:0] n);
		return (n >= RANGE_LO) && (n < RANGE_HI);
	endfunction

endpackage

/* design/nsu_cell.sv */
// ----------------------------------------------------------------------------
// nsu_cell
// One stack entry: a note and a hole flag, exchanged with its neighbors.
// ----------------------------------------------------------------------------
module nsu_cell (
	input  logic          clk,
	input  nsu_pkg::cmd_t cmd,
	input  logic          left,
	input  logic          live,
	input  logic [6:0]    note,
	input  logic [6:0]    lower_val,
	input  logic          lower_hole,
	input  logic [6:0]    upper_val,
	input  logic          upper_hole,
	output logic [6:0]    val,
	output logic          hole
);
	import nsu_pkg::*;

	logic [6:0] val_q;
	logic       hole_q;

	// Sorting swaps a hole upward past a kept entry, one pair per cell pair.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_PUSH: begin
				val_q <= lower_val;
			end
			CMD_MARK: begin
				hole_q <= !live || (val_q == note);
			end
			CMD_SORT_EVEN, CMD_SORT_ODD: begin
				if (left) begin
					if (hole_q && !upper_hole) begin
						val_q  <= upper_val;
						hole_q <= 1'b0;
					end
				end else if (lower_hole && !hole_q) begin
					val_q  <= lower_val;
					hole_q <= 1'b1;
				end
			end
			CMD_SHIFT: begin
				hole_q <= upper_hole;
			end
			default: begin
			end
		endcase
	end

	assign val  = val_q;
	assign hole = hole_q;

endmodule

/* design/nsu_chain.sv */
// ----------------------------------------------------------------------------
// nsu_chain
// Row of cells holding one voice's note stack, top of stack in cell zero.
// ----------------------------------------------------------------------------
module nsu_chain (
	input  logic                       clk,
	input  nsu_pkg::ctl_t              ctl,
	input  logic [nsu_pkg::CNT_W-1:0]  cnt,
	output nsu_pkg::stat_t             stat
);
	import nsu_pkg::*;

	logic [6:0]             val     [STACK_DEPTH];
	logic                   hole    [STACK_DEPTH];
	logic [6:0]             lo_val  [STACK_DEPTH];
	logic                   lo_hole [STACK_DEPTH];
	logic [6:0]             up_val  [STACK_DEPTH];
	logic                   up_hole [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] live;
	logic [STACK_DEPTH-1:0] hit_v;
	logic [STACK_DEPTH-1:0] left;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lo_val[i]  = ctl.note;
			assign lo_hole[i] = 1'b0;
		end else begin : g_mid_lo
			assign lo_val[i]  = val[i-1];
			assign lo_hole[i] = hole[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign up_val[i]  = 7'd0;
			assign up_hole[i] = 1'b1;
		end else begin : g_mid_up
			assign up_val[i]  = val[i+1];
			assign up_hole[i] = hole[i+1];
		end

		assign live[i]  = CNT_W'(i) < cnt;
		assign hit_v[i] = live[i] && (val[i] == ctl.note);
		assign left[i]  = ((i % 2) == 0) ^ (ctl.cmd == CMD_SORT_ODD);

		nsu_cell u_cell (
			.clk        (clk),
			.cmd        (ctl.cmd),
			.left       (left[i]),
			.live       (live[i]),
			.note       (ctl.note),
			.lower_val  (lo_val[i]),
			.lower_hole (lo_hole[i]),
			.upper_val  (up_val[i]),
			.upper_hole (up_hole[i]),
			.val        (val[i]),
			.hole       (hole[i])
		);
	end

	assign stat.top   = val[0];
	assign stat.hole0 = hole[0];
	assign stat.hit   = |hit_v;

endmodule

/* design/midi_voice_note_stack_unit.sv */
// ----------------------------------------------------------------------------
// midi_voice_note_stack_unit
// MIDI parser with running status feeding per-voice last-note-priority stacks.
// ----------------------------------------------------------------------------
// Channel  Direction  Word                    Handshake
// s_*      in         one MIDI byte           s_tvalid and s_tready
// m_*      out        one voice result        m_tvalid and m_tready
//
// One byte is taken at a time; no new byte is taken while the last byte of a
// message or a reset byte is still being handled.
// A note off runs a mark step, odd-even compaction and a count of the kept
// entries in the cell row of each voice concerned, one voice after another.
// arst_n clears the parser, counts and bends and sets the last notes to their
// home values at once; no sweep. A stalled m_tready holds results in the output
// and pending registers.
`include "midi_voice_note_stack_unit_macros.svh"

module midi_voice_note_stack_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] midi_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] voice, [3:2] action, [10:4] note, [17:11] bend_offset,
	// [18] pitch_in_range, [19] all_idle, rest zero
	output logic [nsu_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tlast
);
	import nsu_pkg::*;

	state_t               state_q, state_d;
	logic [7:0]           rs_q;
	logic [1:0]           dbi_q;
	logic [6:0]           fdb_q, val_q;
	logic [VOICE_W-1:0]   voice_q;
	logic                 multi_q;
	logic [VOICE_COUNT-1:0] mask_q;
	logic [IDX_W-1:0]     step_q;
	logic [CNT_W-1:0]     newcnt_q;
	logic [CNT_W-1:0]     cnt_q  [VOICE_COUNT];
	logic [6:0]           lp_q   [VOICE_COUNT];
	logic [6:0]           bend_q [VOICE_COUNT];
	res_t                 pend_q, out_q;
	logic                 pend_v_q, out_v_q, out_last_q;

	ctl_t  ctl  [VOICE_COUNT];
	stat_t stat [VOICE_COUNT];

	logic [3:0]           kind, chan;
	logic                 chan_direct, chan_alloc, is_on, is_off, is_bend;
	logic [VOICE_W-1:0]   chan_voice, target, low_idx;
	logic [VOICE_COUNT-1:0] cand1, cand2, alloc_mask, direct_mask;
	logic [CNT_W-1:0]     cur_cnt;
	logic                 full, others_idle, out_free, can_emit, step_last;
	logic [6:0]           bend_new;
	logic                 emit_en, flush_en;
	res_t                 emit_res;
	cmd_t                 cmd_sel;

	// ---------------- decode ----------------
	assign kind        = rs_q[7:4];
	assign chan        = rs_q[3:0];
	assign chan_direct = chan < 4'(VOICE_COUNT);
	assign chan_alloc  = chan == CHAN_ALLOC;
	assign chan_voice  = chan[VOICE_W-1:0];
	assign is_bend     = (kind == KIND_BEND) && (chan_direct || chan_alloc);
	assign is_on       = (kind == KIND_ON) && (val_q != 7'd0)
	                     && (chan_direct || (chan_alloc && in_range(fdb_q)));
	assign is_off      = ((kind == KIND_OFF) || ((kind == KIND_ON) && (val_q == 7'd0)))
	                     && (chan_direct || chan_alloc);
	assign cur_cnt     = cnt_q[voice_q];
	assign full        = cur_cnt >= CNT_W'(STACK_DEPTH);
	assign bend_new    = val_q ^ BEND_FLIP;
	assign out_free    = !out_v_q || m_tready;
	assign can_emit    = !pend_v_q || out_free;
	assign step_last   = step_q == IDX_W'(STACK_DEPTH - 1);
	assign direct_mask = VOICE_COUNT'(1) << chan_voice;

	// Least-cost voice for an allocated note on; ties keep the lower voice.
	always_comb begin
		logic [8:0] best;
		logic [8:0] cost;
		logic [6:0] diff;
		best   = 9'h1FF;
		target = '0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			diff = (lp_q[v] > fdb_q) ? (lp_q[v] - fdb_q) : (fdb_q - lp_q[v]);
			cost = {2'b00, diff} + ((cnt_q[v] != '0) ? BUSY_COST : 9'd0);
			if (cost < best) begin
				best   = cost;
				target = VOICE_W'(v);
			end
		end
	end

	always_comb begin
		for (int v = 0; v < VOICE_COUNT; v++) begin
			cand1[v] = (cnt_q[v] != '0) && (lp_q[v] != fdb_q) && stat[v].hit;
			cand2[v] = (cnt_q[v] != '0) && (lp_q[v] == fdb_q);
		end
		alloc_mask = (|cand1) ? (cand1 & (~cand1 + VOICE_COUNT'(1))) : cand2;
	end

	always_comb begin
		low_idx = '0;
		for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
			if (mask_q[v]) begin
				low_idx = VOICE_W'(v);
			end
		end
	end

	always_comb begin
		others_idle = 1'b1;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			if ((VOICE_W'(v) != voice_q) && (cnt_q[v] != '0)) begin
				others_idle = 1'b0;
			end
		end
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tdata == BYTE_RESET) begin
						state_d = ST_RESET;
					end else if (!s_tdata[7] && (dbi_q == IDX_SECOND)) begin
						state_d = ST_DISPATCH;
					end
				end
			end
			ST_RESET: begin
				if (can_emit) begin
					state_d = ST_FLUSH;
				end
			end
			ST_DISPATCH: begin
				if (is_bend) begin
					state_d = ST_BEND;
				end else if (is_on) begin
					state_d = ST_ON;
				end else if (is_off) begin
					state_d = ST_OFF_NEXT;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_BEND: begin
				if (((cur_cnt == '0) || can_emit)
				    && (!multi_q || (voice_q == VOICE_W'(VOICE_COUNT - 1)))) begin
					state_d = ST_FLUSH;
				end
			end
			ST_ON: begin
				if (full || can_emit) begin
					state_d = ST_FLUSH;
				end
			end
			ST_OFF_NEXT: begin
				state_d = (mask_q == '0) ? ST_FLUSH : ST_MARK;
			end
			ST_MARK: begin
				state_d = ST_SORT;
			end
			ST_SORT: begin
				if (step_last) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (step_last) begin
					state_d = ST_OFF_EMIT;
				end
			end
			ST_OFF_EMIT: begin
				if (can_emit) begin
					state_d = ST_OFF_NEXT;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	always_comb begin
		s_tready = 1'b0;
		emit_en  = 1'b0;
		emit_res = '0;
		flush_en = 1'b0;
		cmd_sel  = CMD_HOLD;
		emit_res.voice       = 2'(voice_q);
		emit_res.bend_offset = bend_q[voice_q];
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_RESET: begin
				emit_en              = can_emit;
				emit_res.voice       = 2'd0;
				emit_res.action      = ACT_RESET;
				emit_res.bend_offset = '0;
				emit_res.all_idle    = 1'b1;
			end
			ST_BEND: begin
				emit_en                 = (cur_cnt != '0) && can_emit;
				emit_res.action         = ACT_RETUNE;
				emit_res.note           = stat[voice_q].top;
				emit_res.bend_offset    = bend_new;
				emit_res.pitch_in_range = in_range(stat[voice_q].top);
			end
			ST_ON: begin
				emit_en                 = !full && can_emit;
				cmd_sel                 = (!full && can_emit) ? CMD_PUSH : CMD_HOLD;
				emit_res.action         = ACT_OPEN;
				emit_res.note           = fdb_q;
				emit_res.pitch_in_range = in_range(fdb_q);
			end
			ST_MARK: begin
				cmd_sel = CMD_MARK;
			end
			ST_SORT: begin
				cmd_sel = step_q[0] ? CMD_SORT_ODD : CMD_SORT_EVEN;
			end
			ST_COUNT: begin
				cmd_sel = CMD_SHIFT;
			end
			ST_OFF_EMIT: begin
				emit_en = can_emit;
				if (newcnt_q != '0) begin
					emit_res.action         = ACT_RETUNE;
					emit_res.note           = stat[voice_q].top;
					emit_res.pitch_in_range = in_range(stat[voice_q].top);
				end else begin
					emit_res.action   = ACT_CLOSE;
					emit_res.all_idle = others_idle;
				end
			end
			ST_FLUSH: begin
				flush_en = pend_v_q && out_free;
			end
			default: begin
			end
		endcase
	end

	// ---------------- voice stacks ----------------
	always_comb begin
		for (int v = 0; v < VOICE_COUNT; v++) begin
			ctl[v].cmd  = (VOICE_W'(v) == voice_q) ? cmd_sel : CMD_HOLD;
			ctl[v].note = fdb_q;
		end
	end

	for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_voice
		nsu_chain u_chain (
			.clk  (clk),
			.ctl  (ctl[v]),
			.cnt  (cnt_q[v]),
			.stat (stat[v])
		);
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rs_q     <= '0;
			dbi_q    <= IDX_STATUS;
			fdb_q    <= '0;
			voice_q  <= '0;
			multi_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			mask_q   <= '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				cnt_q[v]  <= '0;
				lp_q[v]   <= (v % 2 == 1) ? HOME_ODD : HOME_EVEN;
				bend_q[v] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tdata == BYTE_RESET) begin
							rs_q  <= '0;
							dbi_q <= IDX_STATUS;
							fdb_q <= '0;
							for (int v = 0; v < VOICE_COUNT; v++) begin
								cnt_q[v]  <= '0;
								lp_q[v]   <= (v % 2 == 1) ? HOME_ODD : HOME_EVEN;
								bend_q[v] <= '0;
							end
						end else if (s_tdata >= BYTE_RT_MIN) begin
							// Real-time bytes leave the parser untouched.
						end else if (s_tdata[7]) begin
							rs_q  <= s_tdata;
							dbi_q <= IDX_FIRST;
						end else if (dbi_q == IDX_FIRST) begin
							fdb_q <= s_tdata[6:0];
							dbi_q <= IDX_SECOND;
						end else if (dbi_q == IDX_SECOND) begin
							val_q <= s_tdata[6:0];
							dbi_q <= IDX_FIRST;
						end
					end
				end
				ST_DISPATCH: begin
					voice_q <= chan_alloc ? (is_on ? target : '0) : chan_voice;
					multi_q <= chan_alloc;
					mask_q  <= chan_alloc ? alloc_mask : direct_mask;
				end
				ST_BEND: begin
					if ((cur_cnt == '0) || can_emit) begin
						bend_q[voice_q] <= bend_new;
						if (multi_q && (voice_q != VOICE_W'(VOICE_COUNT - 1))) begin
							voice_q <= voice_q + 1'b1;
						end
					end
				end
				ST_ON: begin
					if (!full && can_emit) begin
						cnt_q[voice_q] <= cur_cnt + 1'b1;
						lp_q[voice_q]  <= fdb_q;
					end
				end
				ST_OFF_NEXT: begin
					if (mask_q != '0) begin
						voice_q         <= low_idx;
						mask_q[low_idx] <= 1'b0;
					end
				end
				ST_MARK: begin
					step_q <= '0;
				end
				ST_SORT: begin
					step_q   <= step_last ? '0 : step_q + 1'b1;
					newcnt_q <= '0;
				end
				ST_COUNT: begin
					// After compaction the kept entries form a prefix; count it.
					step_q   <= step_last ? '0 : step_q + 1'b1;
					newcnt_q <= newcnt_q + CNT_W'(!stat[voice_q].hole0);
				end
				ST_OFF_EMIT: begin
					if (can_emit) begin
						cnt_q[voice_q] <= newcnt_q;
					end
				end
				default: begin
				end
			endcase

			// A result waits in pend_q until the next result or a flush, so the last word of a byte is known.
			if (emit_en) begin
				pend_q   <= emit_res;
				pend_v_q <= 1'b1;
			end else if (flush_en) begin
				pend_v_q <= 1'b0;
			end

			if ((emit_en && pend_v_q) || flush_en) begin
				out_v_q    <= 1'b1;
				out_q      <= pend_q;
				out_last_q <= flush_en;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = TDATA_W'(out_q);
	assign m_tlast  = out_last_q;

	// ---------------- assertions ----------------
	`NSU_ASSERT(a_cnt_bound, cnt_q[voice_q] <= CNT_W'(STACK_DEPTH), "voice count above stack depth")
	`NSU_ASSERT(a_idle_no_pend, s_tready |-> !pend_v_q, "byte taken while a result is pending")
	`NSU_ASSERT(a_sort_exit, (state_q == ST_SORT) |=> (state_q == ST_SORT || state_q == ST_COUNT), "compaction left early")
	`NSU_ASSERT(a_flush_done, (state_q == ST_FLUSH && !pend_v_q) |=> (state_q == ST_IDLE), "flush did not return to idle")
	`NSU_ASSERT_RST(a_rst_quiet, !arst_n |-> !m_tvalid, "output word valid during reset")

endmodule

/* sim/midi_voice_note_stack_unit_test.sv */
// ----------------------------------------------------------------------------
// MIDI voice note stack unit testbench
// Feeds MIDI bytes with running status, predicts the voice results with an
// independent model of the parser and the per-voice note stacks, and checks
// every result word against it while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module midi_voice_note_stack_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import nsu_pkg::*;

	typedef struct packed {
		logic              last;
		logic              all_idle;
		logic              pitch_in_range;
		logic signed [6:0] bend_offset;
		logic [6:0]        note;
		act_t              action;
		logic [1:0]        voice;
	} voice_res_t;

	class voice_scoreboard;
		logic [7:0] run_status;
		logic [1:0] byte_idx;
		logic [6:0] first_data;
		logic [6:0] stack_mem [VOICE_COUNT][STACK_DEPTH];
		int         depth [VOICE_COUNT];
		logic [6:0] last_note [VOICE_COUNT];
		logic [6:0] bend [VOICE_COUNT];
		voice_res_t pending [$];
		voice_res_t batch [$];
		int         errors;

		function void clear();
			run_status = 0;
			byte_idx = IDX_STATUS;
			first_data = 0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				depth[v] = 0;
				bend[v] = 0;
				last_note[v] = (v % 2) ? HOME_ODD : HOME_EVEN;
			end
		endfunction

		function void push_res(int v, act_t a, logic [6:0] n, logic inr, logic idle);
			voice_res_t r;
			r.voice = 2'(v);
			r.action = a;
			r.note = n;
			r.bend_offset = bend[v];
			r.pitch_in_range = inr;
			r.all_idle = idle;
			r.last = 0;
			batch.push_back(r);
		endfunction

		function logic ranged(logic [6:0] n);
			return n >= 69 && n < 89;
		endfunction

		function void note_on(int v, logic [6:0] n);
			if (depth[v] >= STACK_DEPTH) return;
			stack_mem[v][depth[v]] = n;
			depth[v]++;
			last_note[v] = n;
			push_res(v, ACT_OPEN, n, ranged(n), 0);
		endfunction

		function void note_off(int v, logic [6:0] n);
			int w;
			logic idle;
			w = 0;
			for (int r = 0; r < depth[v]; r++)
				if (stack_mem[v][r] != n) begin
					stack_mem[v][w] = stack_mem[v][r];
					w++;
				end
			depth[v] = w;
			if (w > 0) begin
				push_res(v, ACT_RETUNE, stack_mem[v][w-1], ranged(stack_mem[v][w-1]), 0);
			end else begin
				idle = 1;
				for (int k = 0; k < VOICE_COUNT; k++) if (depth[k] != 0) idle = 0;
				push_res(v, ACT_CLOSE, 0, 0, idle);
			end
		endfunction

		function void set_bend(int v, logic [6:0] pb);
			bend[v] = pb ^ BEND_FLIP;
			if (depth[v] > 0)
				push_res(v, ACT_RETUNE, stack_mem[v][depth[v]-1],
					ranged(stack_mem[v][depth[v]-1]), 0);
		endfunction

		function logic holds(int v, logic [6:0] n);
			for (int i = 0; i < depth[v]; i++) if (stack_mem[v][i] == n) return 1;
			return 0;
		endfunction

		function void alloc_on(logic [6:0] n);
			int target, best, cost;
			target = 0;
			best = 32'hFFFF;
			if (!ranged(n)) return;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				cost = (last_note[v] > n) ? last_note[v] - n : n - last_note[v];
				if (depth[v] > 0) cost += 100;
				if (cost < best) begin
					best = cost;
					target = v;
				end
			end
			note_on(target, n);
		endfunction

		function void alloc_off(logic [6:0] n);
			for (int v = 0; v < VOICE_COUNT; v++)
				if (depth[v] > 0 && last_note[v] != n && holds(v, n)) begin
					note_off(v, n);
					return;
				end
			for (int v = 0; v < VOICE_COUNT; v++)
				if (depth[v] > 0 && last_note[v] == n) note_off(v, n);
		endfunction

		function void dispatch(logic [6:0] val);
			logic [3:0] kind, chan;
			kind = run_status[7:4];
			chan = run_status[3:0];
			if (kind == KIND_BEND) begin
				if (chan == CHAN_ALLOC)
					for (int v = 0; v < VOICE_COUNT; v++) set_bend(v, val);
				else if (chan < VOICE_COUNT) set_bend(chan, val);
			end else if (kind == KIND_ON && val != 0) begin
				if (chan == CHAN_ALLOC) alloc_on(first_data);
				else if (chan < VOICE_COUNT) note_on(chan, first_data);
			end else if (kind == KIND_ON || kind == KIND_OFF) begin
				if (chan == CHAN_ALLOC) alloc_off(first_data);
				else if (chan < VOICE_COUNT) note_off(chan, first_data);
			end
		endfunction

		// Notes one accepted byte and queues the results it causes.
		function void note_byte(logic [7:0] b);
			batch.delete();
			if (b == BYTE_RESET) begin
				clear();
				bend[0] = 0;
				push_res(0, ACT_RESET, 0, 0, 1);
			end else if (b >= BYTE_RT_MIN) begin
			end else if (b[7]) begin
				run_status = b;
				byte_idx = IDX_FIRST;
			end else if (byte_idx == IDX_FIRST) begin
				first_data = b[6:0];
				byte_idx = IDX_SECOND;
			end else if (byte_idx == IDX_SECOND) begin
				dispatch(b[6:0]);
				byte_idx = IDX_FIRST;
			end
			if (batch.size() > 0) batch[batch.size()-1].last = 1;
			foreach (batch[i]) pending.push_back(batch[i]);
		endfunction

		function void check_word(voice_res_t got);
			voice_res_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h", $realtime, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				$display("%0t: mismatch expected v%0d a%0d n%0d b%0d r%0d i%0d l%0d",
					$realtime, exp_r.voice, exp_r.action, exp_r.note, exp_r.bend_offset,
					exp_r.pitch_in_range, exp_r.all_idle, exp_r.last);
				$display("%0t:          actual   v%0d a%0d n%0d b%0d r%0d i%0d l%0d",
					$realtime, got.voice, got.action, got.note, got.bend_offset,
					got.pitch_in_range, got.all_idle, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [7:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [TDATA_W-1:0] m_tdata;

	voice_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	int quiet_cycles;
	int words_seen;

	midi_voice_note_stack_unit u_top (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Receiver: ready changes at the falling edge, words are taken at the rising.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_word({m_tlast, m_tdata[RES_W-1:0]});
			words_seen++;
		end
	end

	// The watchdog allows for a four-voice note off behind long stalls.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAIL");
			$finish;
		end
	end

	// Valid stays up between back-to-back bytes and drops only while idling.
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b);
		@(negedge clk);
	endtask

	task automatic send_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
		send_byte(st);
		send_byte({1'b0, d1});
		send_byte({1'b0, d2});
	endtask

	// Mostly well-formed messages on the voice channels, some noise.
	task automatic random_part(int n);
		logic [7:0] st;
		logic [3:0] chan;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: send_byte(8'($urandom_range(255)));
				1: send_byte($urandom_range(12) == 0 ? BYTE_RESET
					: 8'(BYTE_RT_MIN + $urandom_range(6)));
				2: send_msg({KIND_BEND, 4'($urandom_range(5))}, 7'($urandom_range(127)),
					7'($urandom_range(127)));
				default: begin
					chan = $urandom_range(6) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(4));
					st = {($urandom_range(1) ? KIND_ON : KIND_OFF), chan};
					send_byte(st);
					send_byte($urandom_range(1) ? 8'(60 + $urandom_range(35)) : 8'($urandom_range(127)));
					send_byte($urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(127)));
				end
			endcase
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		sb.errors = 0;
		words_seen = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		s_tvalid = 0;
		s_tdata = 0;
		m_tready = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: data before status, real-time, each kind, edges of fields.
		send_byte(8'h40);
		send_byte(8'hF8);
		send_byte(8'hFE);
		send_msg({KIND_ON, 4'd0}, 7'd127, 7'd127);
		send_msg({KIND_ON, 4'd0}, 7'd69, 7'd1);
		send_msg({KIND_BEND, 4'd0}, 7'd0, 7'd127);
		send_msg({KIND_BEND, 4'd1}, 7'd0, 7'd0);
		send_byte(8'h00);
		send_byte(8'h00);
		send_msg({KIND_ON, 4'd0}, 7'd69, 7'd0);
		send_msg({KIND_OFF, 4'd0}, 7'd127, 7'd0);
		send_msg({KIND_OFF, 4'd2}, 7'd5, 7'd64);
		send_msg({KIND_ON, 4'd4}, 7'd88, 7'd100);
		send_msg({KIND_ON, 4'd4}, 7'd89, 7'd100);
		send_msg({KIND_ON, 4'd4}, 7'd70, 7'd100);
		send_msg({KIND_BEND, 4'd4}, 7'd0, 7'd64);
		send_msg({KIND_OFF, 4'd4}, 7'd88, 7'd0);
		send_msg({KIND_ON, 4'd7}, 7'd70, 7'd9);
		send_msg(8'hB0, 7'd7, 7'd9);
		send_byte(BYTE_RESET);
		// Stack repeated notes on voice 3 under running status, then remove
		// every copy of one of them with a single note off.
		send_byte({KIND_ON, 4'd3});
		for (int i = 0; i < 12; i++) begin
			send_byte(8'(60 + i % 3));
			send_byte(8'd90);
		end
		send_msg({KIND_OFF, 4'd3}, 7'd61, 7'd0);
		send_byte(BYTE_RESET);

		send_idle_pct = 0;  recv_stall_pct = 0;  random_part(10);
		send_idle_pct = 75; recv_stall_pct = 0;  random_part(10);
		send_idle_pct = 0;  recv_stall_pct = 75; random_part(10);
		send_idle_pct = 31; recv_stall_pct = 31; random_part(10);
		s_tvalid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
